/* design/ple_pkg.sv */
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

    localparam int ELEM_W  = 32;
    localparam int POS_W   = 8;
    localparam int WHERE_W = 8;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_BADPOS  = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

endpackage

/* design/ple_store.sv */
// Element store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module ple_store
    import ple_pkg::*;
#(
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [ELEM_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [ELEM_W-1:0] o_rdata
);

    logic signed [ELEM_W-1:0] r_mem [DEPTH];
    logic signed [ELEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/positional_list_engine_top.sv */
// Top level of the positional list engine: command sequencer around the element store.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values, kept in list order in
// a single-port-read, single-port-write memory with a registered read.
//
// Command channel: drive i_cmd, i_value, i_position and raise start; the item
// is taken at a rising edge where start is high and busy is low.
//   insert : place i_value at 1-based i_position (0 = after head, past end
//            appends); entries behind it move up one slot.
//   delete : remove the k-th element from the end (k = i_position), return it.
//   search : report the first 1-based position that holds i_value.
//   dump   : emit every element in order, o_last on the final one.
// Result channel: o_strobe is high for exactly one cycle per result; the
// receiver cannot hold results off, so each result is taken as it shows.
//
// Timing: full, empty and bad-k commands answer in the cycle after acceptance
// and never raise busy. Each entry moved or scanned takes a read step and then
// a write or compare step; the last result strobes as busy falls.
// Reset clears the count and the control state; stored entries are not
// cleared, since only entries below the count are ever read.
module positional_list_engine_top
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_cmd,
    input  logic signed [ELEM_W-1:0]  i_value,
    input  logic [POS_W-1:0]          i_position,
    output logic                      o_strobe,
    output logic [2:0]                o_status,
    output logic signed [ELEM_W-1:0]  o_element,
    output logic [WHERE_W-1:0]        o_where,
    output logic                      o_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD0,
        S_DEL_CAP,
        S_DEL_RD,
        S_DEL_WR,
        S_SCAN_RD
    } t_state;

    // Scan compare shares the read/use rhythm; track phase with one flag.
    t_state                   r_state;
    logic                     r_scan_chk;
    t_cmd                     r_cmd;
    logic signed [ELEM_W-1:0] r_value;
    logic signed [ELEM_W-1:0] r_deleted;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_idx;
    logic [CW-1:0]            r_at;

    logic                     r_strobe;
    logic [2:0]               r_status;
    logic signed [ELEM_W-1:0] r_element;
    logic [WHERE_W-1:0]       r_where;
    logic                     r_last;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [ELEM_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic signed [ELEM_W-1:0] rd_data;

    logic                     accept;
    t_cmd                     in_cmd;
    logic [PW-1:0]            pos_ext;
    logic [PW-1:0]            cnt_ext;
    logic [PW-1:0]            pos_m1;
    logic [PW-1:0]            del_at;
    logic [CW-1:0]            ins_at;
    logic [CW-1:0]            idx_dec;
    logic [CW:0]              idx_inc1;
    logic [CW:0]              idx_inc2;
    logic [CW:0]              cnt_wide;
    logic [PW-1:0]            where_full;
    logic                     is_full;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign in_cmd   = t_cmd'(i_cmd);
    assign pos_ext  = PW'(i_position);
    assign cnt_ext  = PW'(r_count);
    assign pos_m1   = pos_ext - PW'(1);
    assign del_at   = cnt_ext - pos_ext;
    assign idx_dec  = r_idx - CW'(1);
    assign idx_inc1 = {1'b0, r_idx} + (CW+1)'(1);
    assign idx_inc2 = {1'b0, r_idx} + (CW+1)'(2);
    assign cnt_wide = {1'b0, r_count};
    assign where_full = PW'(r_idx) + PW'(1);
    assign is_full  = (r_count == CW'(CAPACITY));

    // Insert slot: head for an empty list or position 1, after head for 0,
    // otherwise position-1 clipped to the end of the list.
    always_comb begin
        priority if (r_count == '0 || i_position == POS_W'(1)) begin
            ins_at = '0;
        end else if (i_position == '0) begin
            ins_at = CW'(1);
        end else if (pos_m1 < cnt_ext) begin
            ins_at = pos_m1[CW-1:0];
        end else begin
            ins_at = r_count;
        end
    end

    // Memory port steering.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = rd_data;
        mem_raddr = r_idx[AW-1:0];
        unique case (r_state)
            S_INS_RD: begin
                if (r_idx == r_at) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_value;
                end else begin
                    mem_raddr = idx_dec[AW-1:0];
                end
            end
            S_INS_WR: mem_we = 1'b1;
            S_DEL_RD: mem_raddr = idx_inc1[AW-1:0];
            S_DEL_WR: mem_we = 1'b1;
            default: ;
        endcase
    end

    ple_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_scan_chk <= 1'b0;
            r_count    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd     <= in_cmd;
                        r_value   <= i_value;
                        r_element <= '0;
                        r_where   <= '0;
                        r_last    <= 1'b1;
                        unique case (in_cmd)
                            CMD_INSERT: begin
                                if (is_full) begin
                                    r_strobe <= 1'b1;
                                    r_status <= ST_FULL;
                                end else begin
                                    r_idx   <= r_count;
                                    r_at    <= ins_at;
                                    r_state <= S_INS_RD;
                                end
                            end
                            CMD_DELETE: begin
                                if (r_count == '0) begin
                                    r_strobe <= 1'b1;
                                    r_status <= ST_EMPTY;
                                end else if (i_position == '0 || pos_ext > cnt_ext) begin
                                    r_strobe <= 1'b1;
                                    r_status <= ST_BADPOS;
                                end else begin
                                    r_idx   <= del_at[CW-1:0];
                                    r_state <= S_DEL_RD0;
                                end
                            end
                            default: begin
                                // Search and dump both walk from the head.
                                if (r_count == '0) begin
                                    r_strobe <= 1'b1;
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_idx      <= '0;
                                    r_scan_chk <= 1'b0;
                                    r_state    <= S_SCAN_RD;
                                end
                            end
                        endcase
                    end
                end

                // Move entries up one slot from the tail down to the insert slot.
                S_INS_RD: begin
                    if (r_idx == r_at) begin
                        r_count  <= r_count + CW'(1);
                        r_strobe <= 1'b1;
                        r_status <= ST_OK;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    r_idx   <= idx_dec;
                    r_state <= S_INS_RD;
                end

                // Read the victim, then pull later entries down one slot.
                S_DEL_RD0: r_state <= S_DEL_CAP;
                S_DEL_CAP: begin
                    r_deleted <= rd_data;
                    if (idx_inc1 < cnt_wide) begin
                        r_state <= S_DEL_RD;
                    end else begin
                        r_count   <= r_count - CW'(1);
                        r_strobe  <= 1'b1;
                        r_status  <= ST_OK;
                        r_element <= rd_data;
                        r_state   <= S_IDLE;
                    end
                end
                S_DEL_RD: r_state <= S_DEL_WR;
                S_DEL_WR: begin
                    r_idx <= idx_inc1[CW-1:0];
                    if (idx_inc2 < cnt_wide) begin
                        r_state <= S_DEL_RD;
                    end else begin
                        r_count   <= r_count - CW'(1);
                        r_strobe  <= 1'b1;
                        r_status  <= ST_OK;
                        r_element <= r_deleted;
                        r_state   <= S_IDLE;
                    end
                end

                // Alternate read and check; stop at the tail, or on a hit for a search.
                S_SCAN_RD: begin
                    if (!r_scan_chk) begin
                        r_scan_chk <= 1'b1;
                    end else begin
                        r_scan_chk <= 1'b0;
                        if (r_cmd == CMD_DUMP) begin
                            r_strobe  <= 1'b1;
                            r_status  <= ST_OK;
                            r_element <= rd_data;
                            r_where   <= where_full[WHERE_W-1:0];
                            r_last    <= (idx_inc1 == cnt_wide);
                            if (idx_inc1 == cnt_wide) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_idx <= idx_inc1[CW-1:0];
                            end
                        end else if (rd_data == r_value) begin
                            r_strobe  <= 1'b1;
                            r_status  <= ST_OK;
                            r_element <= r_value;
                            r_where   <= where_full[WHERE_W-1:0];
                            r_last    <= 1'b1;
                            r_state   <= S_IDLE;
                        end else if (idx_inc1 == cnt_wide) begin
                            r_strobe  <= 1'b1;
                            r_status  <= ST_MISSING;
                            r_element <= '0;
                            r_where   <= '0;
                            r_last    <= 1'b1;
                            r_state   <= S_IDLE;
                        end else begin
                            r_idx <= idx_inc1[CW-1:0];
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe  = r_strobe;
    assign o_status  = r_status;
    assign o_element = r_element;
    assign o_where   = r_where;
    assign o_last    = r_last;

endmodule
